@@ rtl/kwm_pkg.sv @@
// ----------------------------------------------------------------------------
// kwm_pkg
// shared constants, codes and control types of the k-way merge core
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int DEF_MAX_LISTS    = 16;
    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int VALUE_W          = 32;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TAKE = 1'b1;

    localparam logic [1:0] ST_LOADED  = 2'd0;
    localparam logic [1:0] ST_GIVEN   = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TREE,
        S_PICK,
        S_ADV,
        S_HEAD,
        S_RESULT
    } kwm_state_t;

    typedef struct packed {
        logic       load_store;
        logic       take_begin;
        logic       pick;
        logic       advance;
        logic       head_load;
        logic       clear_set;
        logic       res_set;
        logic [1:0] res_status;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic load_ok;
        logic draining;
        logic fill_zero;
        logic found;
        logic remaining_zero;
    } dp_status_t;

endpackage

@@ rtl/kwm_if.sv @@
// ----------------------------------------------------------------------------
// kwm_req_if / kwm_rsp_if
// valid/ready channels for request and response beats
// ----------------------------------------------------------------------------
interface kwm_req_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] value;
    logic               end_of_list;

    modport source (output valid, output cmd, output value, output end_of_list,
                    input ready);
    modport sink   (input valid, input cmd, input value, input end_of_list,
                    output ready);
endinterface

interface kwm_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic               last;

    modport source (output valid, output status, output out_value, output last,
                    input ready);
    modport sink   (input valid, input status, input out_value, input last,
                    output ready);
endinterface

@@ rtl/kwm_ram.sv @@
// ----------------------------------------------------------------------------
// kwm_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/kwm_ctrl.sv @@
// ----------------------------------------------------------------------------
// kwm_ctrl
// sequencer for load and take beats, drives the datapath and output beat
// ----------------------------------------------------------------------------
module kwm_ctrl #(
    parameter int MAX_LISTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_cmd,
    output logic               req_ready,
    input  logic               rsp_ready,
    output logic               rsp_valid,
    input  kwm_pkg::dp_status_t st,
    output kwm_pkg::dp_cmd_t   cmd
);
    import kwm_pkg::*;

    localparam int LLW = $clog2(MAX_LISTS);
    localparam int CW  = $clog2(LLW + 1);

    kwm_state_t    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          rsp_valid_reg, rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cnt_next  = '0;
                if (req_valid)
                begin
                    if (req_cmd == CMD_LOAD)
                    begin
                        cmd.res_set = 1'b1;
                        if (st.load_ok)
                        begin
                            cmd.load_store = 1'b1;
                            cmd.res_status = ST_LOADED;
                        end
                        else
                        begin
                            cmd.res_status = ST_REFUSED;
                        end
                        state_next = S_RESULT;
                    end
                    else if (st.draining)
                    begin
                        state_next = S_TREE;
                    end
                    else if (st.fill_zero)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_EMPTY;
                        state_next     = S_RESULT;
                    end
                    else
                    begin
                        cmd.take_begin = 1'b1;
                        state_next     = S_TREE;
                    end
                end
            end
            S_TREE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(LLW))
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (st.found)
                begin
                    cmd.pick   = 1'b1;
                    state_next = S_ADV;
                end
                else
                begin
                    cmd.clear_set  = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_EMPTY;
                    state_next     = S_RESULT;
                end
            end
            S_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = S_HEAD;
            end
            S_HEAD:
            begin
                cmd.head_load = 1'b1;
                cmd.clear_set = st.remaining_zero;
                state_next    = S_RESULT;
            end
            S_RESULT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

@@ rtl/kwm_dp.sv @@
// ----------------------------------------------------------------------------
// kwm_dp
// element store, list bounds, head registers and registered min tree
// ----------------------------------------------------------------------------
module kwm_dp #(
    parameter int MAX_LISTS    = 16,
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] req_value,
    input  logic               req_eol,
    input  kwm_pkg::dp_cmd_t   cmd,
    output kwm_pkg::dp_status_t st,
    output logic [1:0]         rsp_status,
    output logic signed [31:0] rsp_out_value,
    output logic               rsp_last
);
    import kwm_pkg::*;

    localparam int AW   = $clog2(MAX_ELEMENTS);
    localparam int FW   = AW + 1;
    localparam int LLW  = $clog2(MAX_LISTS);
    localparam int CNTW = LLW + 1;
    localparam int NL   = 1 << LLW;

    logic [FW-1:0]        fill_reg;
    logic [FW-1:0]        open_start_reg;
    logic [FW-1:0]        remaining_reg;
    logic [CNTW-1:0]      lc_reg;
    logic                 draining_reg;
    logic [MAX_LISTS-1:0] hv_reg;
    logic signed [31:0]   head_reg [MAX_LISTS];
    logic [LLW-1:0]       best_reg;
    logic                 more_reg;
    logic [1:0]           res_status_reg;
    logic signed [31:0]   res_value_reg;
    logic                 res_last_reg;
    logic [1:0]           out_status_reg;
    logic signed [31:0]   out_value_reg;
    logic                 out_last_reg;

    logic [LLW:0][NL-1:0]            lv_v;
    logic [LLW:0][NL-1:0][31:0]      lv_key;
    logic [LLW:0][NL-1:0][LLW-1:0]   lv_idx;

    logic [LLW-1:0]  lc_idx;
    logic [FW-1:0]   fill_inc;
    logic            close_load;
    logic            close_take;
    logic            close_any;
    logic            list_we;
    logic [LLW-1:0]  list_waddr;
    logic [2*FW-1:0] list_wdata;
    logic [2*FW-1:0] list_rdata;
    logic [FW-1:0]   rp_rd;
    logic [FW-1:0]   end_rd;
    logic [FW-1:0]   nrp;
    logic            more;
    logic [31:0]     store_rdata;

    function automatic logic right_wins(input logic av, input logic signed [31:0] ak,
                                        input logic bv, input logic signed [31:0] bk);
        return bv && (!av || (bk <= ak));
    endfunction

    assign lc_idx     = lc_reg[LLW-1:0];
    assign fill_inc   = fill_reg + 1'b1;
    assign close_load = cmd.load_store && req_eol;
    assign close_take = cmd.take_begin && (fill_reg > open_start_reg)
                        && (lc_reg < CNTW'(MAX_LISTS));
    assign close_any  = close_load || close_take;

    assign rp_rd  = list_rdata[2*FW-1:FW];
    assign end_rd = list_rdata[FW-1:0];
    assign nrp    = rp_rd + 1'b1;
    assign more   = nrp < end_rd;

    assign list_we    = close_any || cmd.advance;
    assign list_waddr = cmd.advance ? best_reg : lc_idx;
    assign list_wdata = cmd.advance ? {nrp, end_rd}
                                    : {open_start_reg, (close_load ? fill_inc : fill_reg)};

    kwm_ram #(
        .WIDTH (2 * FW),
        .DEPTH (MAX_LISTS)
    ) u_list_ram (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (list_wdata),
        .raddr (lv_idx[LLW][0]),
        .rdata (list_rdata)
    );

    kwm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store_ram (
        .clk   (clk),
        .we    (cmd.load_store),
        .waddr (fill_reg[AW-1:0]),
        .wdata (req_value),
        .raddr (nrp[AW-1:0]),
        .rdata (store_rdata)
    );

    assign st.load_ok        = !draining_reg && (fill_reg < FW'(MAX_ELEMENTS))
                               && (lc_reg < CNTW'(MAX_LISTS));
    assign st.draining       = draining_reg;
    assign st.fill_zero      = (fill_reg == '0);
    assign st.found          = lv_v[LLW][0];
    assign st.remaining_zero = (remaining_reg == '0);

    // set bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            open_start_reg <= '0;
            remaining_reg  <= '0;
            lc_reg         <= '0;
            draining_reg   <= 1'b0;
            hv_reg         <= '0;
        end
        else if (cmd.clear_set)
        begin
            fill_reg       <= '0;
            open_start_reg <= '0;
            remaining_reg  <= '0;
            lc_reg         <= '0;
            draining_reg   <= 1'b0;
            hv_reg         <= '0;
        end
        else
        begin
            if (cmd.load_store)
            begin
                fill_reg <= fill_inc;
                if (req_eol)
                begin
                    lc_reg         <= lc_reg + 1'b1;
                    open_start_reg <= fill_inc;
                    hv_reg[lc_idx] <= 1'b1;
                end
            end
            if (cmd.take_begin)
            begin
                remaining_reg <= fill_reg;
                draining_reg  <= 1'b1;
                if (close_take)
                begin
                    lc_reg         <= lc_reg + 1'b1;
                    open_start_reg <= fill_reg;
                    hv_reg[lc_idx] <= 1'b1;
                end
            end
            if (cmd.pick)
            begin
                remaining_reg <= remaining_reg - 1'b1;
            end
            if (cmd.advance && !more)
            begin
                hv_reg[best_reg] <= 1'b0;
            end
        end
    end

    // heads and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_store && (fill_reg == open_start_reg))
        begin
            head_reg[lc_idx] <= req_value;
        end
        if (cmd.head_load && more_reg)
        begin
            head_reg[best_reg] <= store_rdata;
        end
        if (cmd.pick)
        begin
            best_reg       <= lv_idx[LLW][0];
            res_status_reg <= ST_GIVEN;
            res_value_reg  <= lv_key[LLW][0];
            res_last_reg   <= (remaining_reg == FW'(1));
        end
        else if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            res_value_reg  <= '0;
            res_last_reg   <= 1'b0;
        end
        if (cmd.advance)
        begin
            more_reg <= more;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_last_reg   <= res_last_reg;
        end
    end

    // min tree, higher list index wins ties
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NL; j++)
        begin
            if (j < MAX_LISTS)
            begin
                lv_v[0][j]   <= hv_reg[j];
                lv_key[0][j] <= head_reg[j];
            end
            else
            begin
                lv_v[0][j]   <= 1'b0;
                lv_key[0][j] <= '0;
            end
            lv_idx[0][j] <= LLW'(j);
        end
        for (int k = 1; k <= LLW; k++)
        begin
            for (int j = 0; j < NL; j++)
            begin
                if (j < (NL >> k))
                begin
                    if (right_wins(lv_v[k-1][2*j], lv_key[k-1][2*j],
                                   lv_v[k-1][2*j+1], lv_key[k-1][2*j+1]))
                    begin
                        lv_v[k][j]   <= lv_v[k-1][2*j+1];
                        lv_key[k][j] <= lv_key[k-1][2*j+1];
                        lv_idx[k][j] <= lv_idx[k-1][2*j+1];
                    end
                    else
                    begin
                        lv_v[k][j]   <= lv_v[k-1][2*j];
                        lv_key[k][j] <= lv_key[k-1][2*j];
                        lv_idx[k][j] <= lv_idx[k-1][2*j];
                    end
                end
                else
                begin
                    lv_v[k][j]   <= 1'b0;
                    lv_key[k][j] <= '0;
                    lv_idx[k][j] <= '0;
                end
            end
        end
    end

    assign rsp_status    = out_status_reg;
    assign rsp_out_value = out_value_reg;
    assign rsp_last      = out_last_reg;

endmodule

@@ rtl/k_way_sorted_merge_core.sv @@
// ----------------------------------------------------------------------------
// k_way_sorted_merge_core
// merges up to MAX_LISTS loaded ascending lists into one ascending stream
// ----------------------------------------------------------------------------
// Load beats (cmd 0) append a value to the open list, end_of_list closes it;
// take beats (cmd 1) return the smallest remaining head, ties going to the
// higher-numbered list. Every request beat yields exactly one response beat.
// A take that gives an element passes the registered min tree over the list
// heads, then the list bound ram and element ram are read one after the other
// to refill the winning head. The response register lets a new request beat be
// accepted while the previous response waits. There is no clearing pass
// after reset; the set clears itself after its last element is given.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_core #(
    parameter int MAX_LISTS    = kwm_pkg::DEF_MAX_LISTS,
    parameter int MAX_ELEMENTS = kwm_pkg::DEF_MAX_ELEMENTS
) (
    input logic      clk,
    input logic      rst_n,
    kwm_req_if.sink  req,
    kwm_rsp_if.source rsp
);
    import kwm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;

    kwm_ctrl #(
        .MAX_LISTS (MAX_LISTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (req.ready),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .st        (st),
        .cmd       (cmd)
    );

    kwm_dp #(
        .MAX_LISTS    (MAX_LISTS),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_value     (req.value),
        .req_eol       (req.end_of_list),
        .cmd           (cmd),
        .st            (st),
        .rsp_status    (rsp.status),
        .rsp_out_value (rsp.out_value),
        .rsp_last      (rsp.last)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted in consecutive cycles");

    a_non_given_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_GIVEN) |-> (rsp.out_value == 0) && !rsp.last)
        else $error("non-element response carries value or last");

    a_pick_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick |-> st.draining && st.found && !st.remaining_zero)
        else $error("element picked outside a drain");

    a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_store, cmd.take_begin, cmd.pick, cmd.advance, cmd.head_load}))
        else $error("datapath operations overlap");

endmodule
